// File: src/wpmt_pkg.sv
// Shared types, constants and helper functions for window_pair_match_tally.
// Used by the top level and the port checker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package wpmt_pkg;

	// Matrix geometry
	localparam int MAX_WINDOWS = 64;
	localparam int COUNT_BITS  = 16;
	localparam int SIDE        = MAX_WINDOWS + 1;
	localparam int DEPTH       = SIDE * SIDE;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int IDX_W       = $clog2(MAX_WINDOWS + 2);

	// Field widths
	localparam int WIN_W    = 7;
	localparam int HALF_W   = 15;
	localparam int THR_W    = 16;
	localparam int START_W  = 16;
	localparam int CELL_W   = 7;
	localparam int PCOUNT_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Stream payload layout
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 24;

	// Serial divider
	localparam int DIV_STEPS = START_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// Opcodes carried in tuser
	localparam logic OP_TALLY = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOWS_A    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOWS_B    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd4;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIVIDE,
		ST_INDEX,
		ST_PLAN,
		ST_BUMP_RD,
		ST_BUMP_WR,
		ST_READ_OUT
	} wpmt_state_t;

	typedef struct packed {
		logic [HALF_W-1:0]  rem;
		logic [START_W-1:0] quo;
	} div_reg_t;

	// Window count limited to 1..MAX_WINDOWS
	function automatic logic [IDX_W-1:0] eff_windows(input logic [WIN_W-1:0] w);
		if (w == '0)
			return IDX_W'(1);
		else if (32'(w) > MAX_WINDOWS)
			return IDX_W'(MAX_WINDOWS);
		else
			return IDX_W'(w);
	endfunction

	// Zero divisor acts as one
	function automatic logic [HALF_W-1:0] eff_half(input logic [HALF_W-1:0] h);
		return (h == '0) ? HALF_W'(1) : h;
	endfunction

	// One restoring radix-2 step: shift in the next dividend bit, subtract if it fits
	function automatic div_reg_t div_step(input div_reg_t r, input logic [HALF_W-1:0] d);
		logic [HALF_W:0] sh;
		div_reg_t        n;
		sh = {r.rem, r.quo[START_W-1]};
		if (sh >= {1'b0, d}) begin
			n.rem = HALF_W'(sh - {1'b0, d});
			n.quo = {r.quo[START_W-2:0], 1'b1};
		end else begin
			n.rem = sh[HALF_W-1:0];
			n.quo = {r.quo[START_W-2:0], 1'b0};
		end
		return n;
	endfunction

	// Quotient clamped to window count plus one
	function automatic logic [IDX_W-1:0] clamp_index(input logic [START_W-1:0] q,
		input logic [IDX_W-1:0] w);
		logic [IDX_W-1:0] lim;
		lim = w + IDX_W'(1);
		if (32'(q) > 32'(lim))
			return lim;
		else
			return IDX_W'(q);
	endfunction

	// Cell address, row major
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
		input logic [IDX_W-1:0] col);
		return ADDR_W'(row) * ADDR_W'(SIDE) + ADDR_W'(col);
	endfunction

	// Count as shown on the output, saturated to the field
	function automatic logic [PCOUNT_W-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
		if (32'(c) > 32'({PCOUNT_W{1'b1}}))
			return '1;
		else
			return PCOUNT_W'(c);
	endfunction

endpackage

`default_nettype wire

// File: src/wpmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wpmt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// File: src/window_pair_match_tally.sv
// Top level of window_pair_match_tally: config registers, serial dividers,
// control FSM and output register. Uses wpmt_pkg and wpmt_ram.
//
// Usage:
//   Input stream s_*: s_tuser is the opcode (tally or read-and-clear),
//   s_tdata carries start_a, start_b, cell_row, cell_col. Output stream m_*
//   carries one result per read: pair_count and meets_threshold. Tallies
//   give no result. Registers are written on the cfg_* channel, which is
//   always ready; write them only while the block is idle.
//   After reset the counter RAM is swept to zero, one cell per cycle,
//   through every cell; s_tready stays low during the sweep.
//   A tally runs two radix-2 dividers in parallel, then clamps the window
//   indexes, then plans the bumps; each bump is a read-modify-write, and a
//   bump whose cell lies outside the matrix is skipped. s_tready stays low
//   until the tally is done. A read loads the output register once it is
//   free; the result is then visible on m_* until taken. If the receiver
//   stalls, the next item is still accepted; a following read waits until
//   the output register empties.
`timescale 1ns / 1ps
`default_nettype none

module window_pair_match_tally (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// input stream
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// [15:0] start_a, [31:16] start_b, [38:32] cell_row, [45:39] cell_col
	input  wire logic [wpmt_pkg::IN_TDATA_W-1:0]      s_tdata,
	// [0] opcode
	input  wire logic                                 s_tuser,
	// output stream
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// [15:0] pair_count, [16] meets_threshold, rest zero
	output logic      [wpmt_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// configuration writes
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [wpmt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [wpmt_pkg::CFG_DATA_W-1:0]      cfg_data
);

	wpmt_pkg::wpmt_state_t state_q, state_nx;

	// config registers
	logic [wpmt_pkg::WIN_W-1:0]  windows_a_q, windows_b_q;
	logic [wpmt_pkg::HALF_W-1:0] half_a_q, half_b_q;
	logic [wpmt_pkg::THR_W-1:0]  threshold_q;

	logic [wpmt_pkg::IDX_W-1:0]  wa, wb;
	logic [wpmt_pkg::HALF_W-1:0] da, db;

	// datapath registers
	logic [wpmt_pkg::ADDR_W-1:0]    clr_addr_q;
	wpmt_pkg::div_reg_t             div_a_q, div_b_q;
	logic [wpmt_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [wpmt_pkg::IDX_W-1:0]     a_idx_q, b_idx_q;
	logic [wpmt_pkg::ADDR_W-1:0]    bump_addr_q [2];
	logic [1:0]                     bump_ok_q;
	logic                           bump_two_q;
	logic                           bump_sel_q;
	logic                           read_ok_q;
	logic [wpmt_pkg::ADDR_W-1:0]    read_addr_q;
	logic                           m_tvalid_q;
	logic [wpmt_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	// RAM ports
	logic                              ram_wr_en, ram_rd_en;
	logic [wpmt_pkg::ADDR_W-1:0]       ram_wr_addr, ram_rd_addr;
	logic [wpmt_pkg::COUNT_BITS-1:0]   ram_wr_data, ram_rd_data;

	// input fields
	logic [wpmt_pkg::START_W-1:0] in_start_a, in_start_b;
	logic [wpmt_pkg::CELL_W-1:0]  in_row, in_col;
	logic                         s_xfer, out_free, last_div;

	// bump plan
	logic [wpmt_pkg::IDX_W-1:0] r0, c0, r1, c1;
	logic                       two;

	logic [wpmt_pkg::ADDR_W-1:0]     cur_addr;
	logic [wpmt_pkg::COUNT_BITS-1:0] read_count;

	assign in_start_a = s_tdata[15:0];
	assign in_start_b = s_tdata[31:16];
	assign in_row     = s_tdata[38:32];
	assign in_col     = s_tdata[45:39];

	assign wa = wpmt_pkg::eff_windows(windows_a_q);
	assign wb = wpmt_pkg::eff_windows(windows_b_q);
	assign da = wpmt_pkg::eff_half(half_a_q);
	assign db = wpmt_pkg::eff_half(half_b_q);

	assign s_xfer   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign last_div = (div_cnt_q == wpmt_pkg::DIV_CNT_W'(wpmt_pkg::DIV_STEPS - 1));
	assign cur_addr = bump_addr_q[bump_sel_q];
	assign read_count = read_ok_q ? ram_rd_data : '0;

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			windows_a_q <= wpmt_pkg::WIN_W'(1);
			windows_b_q <= wpmt_pkg::WIN_W'(1);
			half_a_q    <= wpmt_pkg::HALF_W'(1);
			half_b_q    <= wpmt_pkg::HALF_W'(1);
			threshold_q <= wpmt_pkg::THR_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wpmt_pkg::REG_WINDOWS_A:    windows_a_q <= cfg_data[wpmt_pkg::WIN_W-1:0];
				wpmt_pkg::REG_WINDOWS_B:    windows_b_q <= cfg_data[wpmt_pkg::WIN_W-1:0];
				wpmt_pkg::REG_HALF_WIDTH_A: half_a_q    <= cfg_data[wpmt_pkg::HALF_W-1:0];
				wpmt_pkg::REG_HALF_WIDTH_B: half_b_q    <= cfg_data[wpmt_pkg::HALF_W-1:0];
				wpmt_pkg::REG_THRESHOLD:    threshold_q <= cfg_data[wpmt_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// bump plan from the clamped window indexes
	always_comb begin
		r0  = a_idx_q - wpmt_pkg::IDX_W'(1);
		c0  = b_idx_q - wpmt_pkg::IDX_W'(1);
		r1  = '0;
		c1  = '0;
		two = 1'b0;
		if (a_idx_q == '0 || b_idx_q == '0) begin
			// first window on one or both sides
			if (a_idx_q == b_idx_q) begin
				r0 = '0;
				c0 = '0;
			end else if (a_idx_q == '0) begin
				r0  = '0;
				c0  = b_idx_q;
				r1  = '0;
				c1  = b_idx_q - wpmt_pkg::IDX_W'(1);
				two = 1'b1;
			end else begin
				r0  = a_idx_q;
				c0  = '0;
				r1  = a_idx_q - wpmt_pkg::IDX_W'(1);
				c1  = '0;
				two = 1'b1;
			end
		end else if (a_idx_q >= wa || b_idx_q >= wb) begin
			// last window on one or both sides
			if (a_idx_q >= wa && b_idx_q >= wb) begin
				two = 1'b0;
			end else if (a_idx_q >= wa) begin
				c0  = b_idx_q;
				r1  = a_idx_q - wpmt_pkg::IDX_W'(1);
				c1  = b_idx_q - wpmt_pkg::IDX_W'(1);
				two = 1'b1;
			end else begin
				r0  = a_idx_q;
				r1  = a_idx_q - wpmt_pkg::IDX_W'(1);
				c1  = b_idx_q - wpmt_pkg::IDX_W'(1);
				two = 1'b1;
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= wpmt_pkg::ST_CLEAR;
		else
			state_q <= state_nx;
	end

	// next state and RAM control
	always_comb begin
		state_nx    = state_q;
		s_tready    = 1'b0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = '0;
		ram_wr_data = '0;
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		case (state_q)
			wpmt_pkg::ST_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = clr_addr_q;
				if (clr_addr_q == wpmt_pkg::ADDR_W'(wpmt_pkg::DEPTH - 1))
					state_nx = wpmt_pkg::ST_IDLE;
			end
			wpmt_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser == wpmt_pkg::OP_READ) begin
						// read issued at once, data lands next cycle
						ram_rd_en   = 1'b1;
						ram_rd_addr = wpmt_pkg::cell_addr(wpmt_pkg::IDX_W'(in_row),
							wpmt_pkg::IDX_W'(in_col));
						state_nx    = wpmt_pkg::ST_READ_OUT;
					end else begin
						state_nx = wpmt_pkg::ST_DIVIDE;
					end
				end
			end
			wpmt_pkg::ST_DIVIDE: begin
				if (last_div)
					state_nx = wpmt_pkg::ST_INDEX;
			end
			wpmt_pkg::ST_INDEX: state_nx = wpmt_pkg::ST_PLAN;
			wpmt_pkg::ST_PLAN:  state_nx = wpmt_pkg::ST_BUMP_RD;
			wpmt_pkg::ST_BUMP_RD: begin
				if (bump_ok_q[bump_sel_q]) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = cur_addr;
					state_nx    = wpmt_pkg::ST_BUMP_WR;
				end else if (!(bump_two_q && !bump_sel_q)) begin
					state_nx = wpmt_pkg::ST_IDLE;
				end
			end
			wpmt_pkg::ST_BUMP_WR: begin
				// saturating increment
				ram_wr_en   = 1'b1;
				ram_wr_addr = cur_addr;
				ram_wr_data = (ram_rd_data == wpmt_pkg::COUNT_MAX) ? ram_rd_data :
					ram_rd_data + wpmt_pkg::COUNT_BITS'(1);
				if (bump_two_q && !bump_sel_q)
					state_nx = wpmt_pkg::ST_BUMP_RD;
				else
					state_nx = wpmt_pkg::ST_IDLE;
			end
			wpmt_pkg::ST_READ_OUT: begin
				// clear the cell as the result is loaded
				if (out_free) begin
					ram_wr_en   = read_ok_q;
					ram_wr_addr = read_addr_q;
					state_nx    = wpmt_pkg::ST_IDLE;
				end
			end
			default: state_nx = wpmt_pkg::ST_IDLE;
		endcase
	end

	// control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			div_cnt_q  <= '0;
			bump_sel_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == wpmt_pkg::ST_CLEAR)
				clr_addr_q <= clr_addr_q + wpmt_pkg::ADDR_W'(1);
			if (s_xfer)
				div_cnt_q <= '0;
			else if (state_q == wpmt_pkg::ST_DIVIDE)
				div_cnt_q <= div_cnt_q + wpmt_pkg::DIV_CNT_W'(1);
			if (state_q == wpmt_pkg::ST_PLAN)
				bump_sel_q <= 1'b0;
			else if ((state_q == wpmt_pkg::ST_BUMP_WR ||
				(state_q == wpmt_pkg::ST_BUMP_RD && !bump_ok_q[bump_sel_q])) &&
				bump_two_q && !bump_sel_q)
				bump_sel_q <= 1'b1;
			if (state_q == wpmt_pkg::ST_READ_OUT && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			div_a_q     <= '{rem: '0, quo: in_start_a};
			div_b_q     <= '{rem: '0, quo: in_start_b};
			read_ok_q   <= (32'(in_row) <= wpmt_pkg::MAX_WINDOWS) &&
				(32'(in_col) <= wpmt_pkg::MAX_WINDOWS);
			read_addr_q <= wpmt_pkg::cell_addr(wpmt_pkg::IDX_W'(in_row),
				wpmt_pkg::IDX_W'(in_col));
		end else if (state_q == wpmt_pkg::ST_DIVIDE) begin
			div_a_q <= wpmt_pkg::div_step(div_a_q, da);
			div_b_q <= wpmt_pkg::div_step(div_b_q, db);
		end
		if (state_q == wpmt_pkg::ST_INDEX) begin
			a_idx_q <= wpmt_pkg::clamp_index(div_a_q.quo, wa);
			b_idx_q <= wpmt_pkg::clamp_index(div_b_q.quo, wb);
		end
		if (state_q == wpmt_pkg::ST_PLAN) begin
			bump_addr_q[0] <= wpmt_pkg::cell_addr(r0, c0);
			bump_addr_q[1] <= wpmt_pkg::cell_addr(r1, c1);
			bump_ok_q[0]   <= (r0 <= wa) && (c0 <= wb);
			bump_ok_q[1]   <= (r1 <= wa) && (c1 <= wb);
			bump_two_q     <= two;
		end
		if (state_q == wpmt_pkg::ST_READ_OUT && out_free) begin
			m_tdata_q <= {(wpmt_pkg::OUT_TDATA_W - wpmt_pkg::PCOUNT_W - 1)'(0),
				(32'(read_count) >= 32'(threshold_q)),
				wpmt_pkg::sat_count(read_count)};
		end
	end

	wpmt_ram #(
		.WIDTH (wpmt_pkg::COUNT_BITS),
		.DEPTH (wpmt_pkg::DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

endmodule

`default_nettype wire

// File: src/wpmt_checker.sv
// Port-level checker for window_pair_match_tally, bound to the top level.
// Uses wpmt_pkg for port widths.
`timescale 1ns / 1ps
`default_nettype none

module wpmt_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 s_tvalid,
	input wire logic                                 s_tready,
	input wire logic                                 m_tvalid,
	input wire logic                                 m_tready,
	input wire logic [wpmt_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// every item leaves the block busy right after its transfer
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transfer");

	// a new result only comes out of a busy cycle
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without work in progress");

	// padding above meets_threshold stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[wpmt_pkg::OUT_TDATA_W-1:wpmt_pkg::PCOUNT_W+1] == '0)
		else $error("nonzero padding in result");

endmodule

bind window_pair_match_tally wpmt_checker u_wpmt_checker (.*);

`default_nettype wire
